// ===== sv/tmlc_pkg.sv =====
// shared types, widths and codes for the task masked lru cache
package tmlc_pkg;

  localparam int unsigned MaxSetsDef   = 64;
  localparam int unsigned MaxWaysDef   = 8;
  localparam int unsigned TaskSlotsDef = 16;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned TASK_W   = 4;
  localparam int unsigned LINE_W   = 31;
  localparam int unsigned MASK_W   = 64;
  localparam int unsigned TOUCH_W  = 64;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned SETC_W   = 7;
  localparam int unsigned WAYC_W   = 4;
  localparam int unsigned EWAY_W   = 6;
  localparam int unsigned PC_W     = 7;
  localparam int unsigned BIT_W    = 6;
  localparam int unsigned DSTEP_W  = 5;
  localparam int unsigned CFGIDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_ACCESS = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELOAD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MASK   = 2'd2;

  localparam logic [CFGIDX_W-1:0] CFG_SET_COUNT = 1'b0;
  localparam logic [CFGIDX_W-1:0] CFG_WAY_COUNT = 1'b1;

  localparam logic [SETC_W-1:0] SET_COUNT_RST = 7'd64;
  localparam logic [WAYC_W-1:0] WAY_COUNT_RST = 4'd8;

  typedef struct packed {
    logic                valid;
    logic [TASK_W-1:0]   owner;
    logic [LINE_W-1:0]   line;
    logic [TOUCH_W-1:0]  touch;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic mask_wr;
    logic tick_inc;
    logic pc_init;
    logic pc_step;
    logic div_init;
    logic div_step;
    logic sel_init;
    logic sel_step;
    logic rd;
    logic rld;
    logic chk;
    logic wr;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bit_last;
    logic div_last;
    logic pc_zero;
    logic sel_hit;
    logic match;
    logic way_last;
    logic set_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/tmlc_if.sv =====
// request and response channel interfaces
interface tmlc_req_if;
  logic                        valid;
  logic                        ready;
  logic [tmlc_pkg::REQ_W-1:0]  req_type;
  logic [tmlc_pkg::TASK_W-1:0] task_id;
  logic [tmlc_pkg::LINE_W-1:0] line_number;
  logic [tmlc_pkg::MASK_W-1:0] mask_value;
  modport source (output valid, req_type, task_id, line_number, mask_value, input ready);
  modport sink (input valid, req_type, task_id, line_number, mask_value, output ready);
endinterface

interface tmlc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         evicted_valid;
  logic [tmlc_pkg::TASK_W-1:0]  victim_task;
  logic [tmlc_pkg::LINE_W-1:0]  evicted_line;
  logic [tmlc_pkg::TOTAL_W-1:0] cross_evictions_total;
  modport source (output valid, hit, evicted_valid, victim_task, evicted_line,
                  cross_evictions_total, input ready);
  modport sink (input valid, hit, evicted_valid, victim_task, evicted_line,
                cross_evictions_total, output ready);
endinterface

// ===== sv/tmlc_ram.sv =====
// generic single write, single read ram with registered read data
module tmlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tmlc_dp.sv =====
// datapath: config, masks, set pick arithmetic, way scan, entry ram and result register
module tmlc_dp #(
  parameter int unsigned MaxSets   = tmlc_pkg::MaxSetsDef,
  parameter int unsigned MaxWays   = tmlc_pkg::MaxWaysDef,
  parameter int unsigned TaskSlots = tmlc_pkg::TaskSlotsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tmlc_pkg::cmd_t                  cmd_i,
  output tmlc_pkg::sts_t                  sts_o,
  input  logic                            cfg_we_i,
  input  logic [tmlc_pkg::CFGIDX_W-1:0]   cfg_idx_i,
  input  logic [tmlc_pkg::SETC_W-1:0]     cfg_data_i,
  input  logic [tmlc_pkg::TASK_W-1:0]     task_id_i,
  input  logic [tmlc_pkg::LINE_W-1:0]     line_number_i,
  input  logic [tmlc_pkg::MASK_W-1:0]     mask_value_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            hit_o,
  output logic                            evicted_valid_o,
  output logic [tmlc_pkg::TASK_W-1:0]     victim_task_o,
  output logic [tmlc_pkg::LINE_W-1:0]     evicted_line_o,
  output logic [tmlc_pkg::TOTAL_W-1:0]    cross_evictions_total_o
);

  localparam int unsigned Depth = MaxSets * MaxWays;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SetIw = (MaxSets > 1) ? $clog2(MaxSets) : 1;
  localparam int unsigned WayIw = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned SlotW = (TaskSlots > 1) ? $clog2(TaskSlots) : 1;
  localparam int unsigned TaskVals = 2 ** tmlc_pkg::TASK_W;

  localparam int unsigned SW = tmlc_pkg::SETC_W;
  localparam int unsigned EW = tmlc_pkg::EWAY_W;

  logic [SW-1:0]                   set_count_q;
  logic [tmlc_pkg::WAYC_W-1:0]     way_count_q;
  logic [tmlc_pkg::MASK_W-1:0]     masks_q [TaskSlots];
  logic [tmlc_pkg::TASK_W-1:0]     task_q;
  logic [tmlc_pkg::LINE_W-1:0]     line_q;
  logic [tmlc_pkg::MASK_W-1:0]     mask_in_q;
  logic [tmlc_pkg::TOUCH_W-1:0]    tick_q;
  logic [tmlc_pkg::TOTAL_W-1:0]    total_q;
  logic [tmlc_pkg::MASK_W-1:0]     m_q;
  logic [tmlc_pkg::PC_W-1:0]       pc_q;
  logic [tmlc_pkg::BIT_W-1:0]      bit_q;
  logic [SW-1:0]                   rem_q;
  logic [tmlc_pkg::DSTEP_W-1:0]    dstep_q;
  logic [SW-1:0]                   ord_q;
  logic [SetIw-1:0]                set_q;
  logic [SetIw-1:0]                rset_q;
  logic [WayIw-1:0]                way_q;
  logic                            free_q;
  logic [WayIw-1:0]                vic_way_q;
  logic                            vic_valid_q;
  logic [tmlc_pkg::TASK_W-1:0]     vic_owner_q;
  logic [tmlc_pkg::LINE_W-1:0]     vic_line_q;
  logic [tmlc_pkg::TOUCH_W-1:0]    old_touch_q;
  logic                            hit_q;
  logic                            ev_valid_q;
  logic [tmlc_pkg::TASK_W-1:0]     ev_owner_q;
  logic [tmlc_pkg::LINE_W-1:0]     ev_line_q;
  logic [AddrW-1:0]                clr_q;
  logic                            out_valid_q;
  logic                            out_hit_q;
  logic                            out_ev_valid_q;
  logic [tmlc_pkg::TASK_W-1:0]     out_ev_owner_q;
  logic [tmlc_pkg::LINE_W-1:0]     out_ev_line_q;
  logic [tmlc_pkg::TOTAL_W-1:0]    out_total_q;

  logic [SlotW-1:0]                slot_lut [TaskVals];
  logic [SlotW-1:0]                slot;
  logic [SW-1:0]                   nsets;
  logic [EW-1:0]                   nways;
  logic [tmlc_pkg::MASK_W-1:0]     in_use;
  logic [SW-1:0]                   divisor;
  logic [SW:0]                     div_try;
  logic [SW:0]                     div_sub;
  logic                            pc_zero;
  logic                            sel_hit;
  logic [SetIw-1:0]                rd_set;
  logic [AddrW-1:0]                raddr;
  logic [AddrW-1:0]                waddr;
  logic [WayIw-1:0]                wr_way;
  logic                            ram_we;
  logic [AddrW-1:0]                ram_waddr;
  tmlc_pkg::entry_t                ram_wdata;
  tmlc_pkg::entry_t                ent;
  logic [tmlc_pkg::ENTRY_W-1:0]    rdata;
  logic                            match;
  logic                            way_last;
  logic                            set_last;
  logic                            cross_ev;
  logic                            out_free;

  // task id to mask slot, folded at elaboration
  for (genvar t = 0; t < TaskVals; t++) begin : g_slot
    assign slot_lut[t] = SlotW'(t % TaskSlots);
  end
  assign slot = slot_lut[task_q];

  assign nsets = (set_count_q == '0) ? SW'(1) :
                 ((set_count_q > SW'(MaxSets)) ? SW'(MaxSets) : set_count_q);
  assign nways = (way_count_q == '0) ? EW'(1) :
                 (({2'b00, way_count_q} > EW'(MaxWays)) ? EW'(MaxWays)
                                                        : {2'b00, way_count_q});
  assign in_use = (nsets >= SW'(64)) ? '1
                : ((tmlc_pkg::MASK_W'(1) << nsets) - tmlc_pkg::MASK_W'(1));

  assign pc_zero = (pc_q == '0);
  assign divisor = pc_zero ? nsets : pc_q;
  assign div_try = {rem_q, line_q[dstep_q]};
  assign div_sub = div_try - {1'b0, divisor};
  assign sel_hit = m_q[bit_q] && (ord_q == '0);

  assign rd_set = cmd_i.rld ? rset_q : set_q;
  assign raddr  = AddrW'(rd_set) * AddrW'(MaxWays) + AddrW'(way_q);
  assign wr_way = hit_q ? way_q : vic_way_q;
  assign waddr  = AddrW'(set_q) * AddrW'(MaxWays) + AddrW'(wr_way);

  assign ent      = tmlc_pkg::entry_t'(rdata);
  assign match    = ent.valid && (ent.owner == task_q) && (ent.line == line_q);
  assign way_last = (EW'(way_q) == (nways - EW'(1)));
  assign set_last = (SW'(rset_q) == (nsets - SW'(1)));
  assign cross_ev = vic_valid_q && (vic_owner_q != task_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr;
    ram_wdata = '0;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
    end else if (cmd_i.wr) begin
      ram_we          = 1'b1;
      ram_wdata.valid = 1'b1;
      ram_wdata.owner = task_q;
      ram_wdata.line  = line_q;
      ram_wdata.touch = tick_q;
    end
  end

  tmlc_ram #(
    .Width (tmlc_pkg::ENTRY_W),
    .Depth (Depth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // config and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_count_q <= tmlc_pkg::SET_COUNT_RST;
      way_count_q <= tmlc_pkg::WAY_COUNT_RST;
      for (int i = 0; i < TaskSlots; i++) begin
        masks_q[i] <= '1;
      end
      tick_q      <= '0;
      total_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tmlc_pkg::CFG_SET_COUNT: set_count_q <= cfg_data_i;
          tmlc_pkg::CFG_WAY_COUNT: way_count_q <= cfg_data_i[tmlc_pkg::WAYC_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.mask_wr) begin
        masks_q[slot] <= mask_in_q;
      end
      if (cmd_i.tick_inc) begin
        tick_q <= tick_q + tmlc_pkg::TOUCH_W'(1);
      end
      if (cmd_i.wr && !hit_q && cross_ev) begin
        total_q <= total_q + tmlc_pkg::TOTAL_W'(1);
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (cmd_i.result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      task_q     <= task_id_i;
      line_q     <= line_number_i;
      mask_in_q  <= mask_value_i;
      hit_q      <= 1'b0;
      ev_valid_q <= 1'b0;
      ev_owner_q <= '0;
      ev_line_q  <= '0;
      way_q      <= '0;
      rset_q     <= '0;
    end
    if (cmd_i.pc_init) begin
      m_q   <= masks_q[slot] & in_use;
      pc_q  <= '0;
      bit_q <= '0;
    end
    if (cmd_i.pc_step) begin
      pc_q  <= pc_q + tmlc_pkg::PC_W'(m_q[bit_q]);
      bit_q <= bit_q + tmlc_pkg::BIT_W'(1);
    end
    if (cmd_i.div_init) begin
      rem_q   <= '0;
      dstep_q <= tmlc_pkg::DSTEP_W'(tmlc_pkg::LINE_W - 1);
    end
    if (cmd_i.div_step) begin
      // restoring step, one line bit per cycle from the top
      rem_q   <= (div_try >= {1'b0, divisor}) ? div_sub[SW-1:0] : div_try[SW-1:0];
      dstep_q <= dstep_q - tmlc_pkg::DSTEP_W'(1);
    end
    if (cmd_i.sel_init) begin
      ord_q  <= rem_q;
      bit_q  <= '0;
      way_q  <= '0;
      free_q <= 1'b0;
      if (pc_zero) begin
        set_q <= SetIw'(rem_q);
      end
    end
    if (cmd_i.sel_step) begin
      if (m_q[bit_q] && (ord_q != '0)) begin
        ord_q <= ord_q - SW'(1);
      end
      if (sel_hit) begin
        set_q <= SetIw'(bit_q);
      end
      bit_q <= bit_q + tmlc_pkg::BIT_W'(1);
    end
    if (cmd_i.chk) begin
      if (match) begin
        hit_q <= 1'b1;
      end else if (cmd_i.rld) begin
        if (way_last) begin
          way_q  <= '0;
          rset_q <= rset_q + SetIw'(1);
        end else begin
          way_q <= way_q + WayIw'(1);
        end
      end else begin
        way_q <= way_q + WayIw'(1);
        if (!free_q) begin
          if (!ent.valid) begin
            free_q      <= 1'b1;
            vic_way_q   <= way_q;
            vic_valid_q <= 1'b0;
          end else if ((way_q == '0) || (ent.touch < old_touch_q)) begin
            old_touch_q <= ent.touch;
            vic_way_q   <= way_q;
            vic_valid_q <= 1'b1;
            vic_owner_q <= ent.owner;
            vic_line_q  <= ent.line;
          end
        end
      end
    end
    if (cmd_i.wr && !hit_q && cross_ev) begin
      ev_valid_q <= 1'b1;
      ev_owner_q <= vic_owner_q;
      ev_line_q  <= vic_line_q;
    end
    if (cmd_i.result_load) begin
      out_hit_q      <= hit_q;
      out_ev_valid_q <= ev_valid_q;
      out_ev_owner_q <= ev_owner_q;
      out_ev_line_q  <= ev_line_q;
      out_total_q    <= total_q;
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.clr_last = (clr_q == AddrW'(Depth - 1));
    sts_o.bit_last = (bit_q == '1);
    sts_o.div_last = (dstep_q == '0);
    sts_o.pc_zero  = pc_zero;
    sts_o.sel_hit  = sel_hit;
    sts_o.match    = match;
    sts_o.way_last = way_last;
    sts_o.set_last = set_last;
    sts_o.out_free = out_free;
  end

  assign out_valid_o             = out_valid_q;
  assign hit_o                   = out_hit_q;
  assign evicted_valid_o         = out_ev_valid_q;
  assign victim_task_o           = out_ev_owner_q;
  assign evicted_line_o          = out_ev_line_q;
  assign cross_evictions_total_o = out_total_q;

endmodule

// ===== sv/tmlc_ctrl.sv =====
// controller state machine sequencing each item through the datapath
module tmlc_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [tmlc_pkg::REQ_W-1:0]   in_req_type_i,
  output logic                         in_ready_o,
  input  tmlc_pkg::sts_t               sts_i,
  output tmlc_pkg::cmd_t               cmd_o
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_MASKW   = 4'd2;
  localparam logic [3:0] S_TICK    = 4'd3;
  localparam logic [3:0] S_PC      = 4'd4;
  localparam logic [3:0] S_DIVI    = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_SELI    = 4'd7;
  localparam logic [3:0] S_SEL     = 4'd8;
  localparam logic [3:0] S_SCAN_RD = 4'd9;
  localparam logic [3:0] S_SCAN_CK = 4'd10;
  localparam logic [3:0] S_WR      = 4'd11;
  localparam logic [3:0] S_RLD_RD  = 4'd12;
  localparam logic [3:0] S_RLD_CK  = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          unique case (in_req_type_i)
            tmlc_pkg::REQ_ACCESS: state_d = S_TICK;
            tmlc_pkg::REQ_RELOAD: state_d = S_RLD_RD;
            tmlc_pkg::REQ_MASK:   state_d = S_MASKW;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_MASKW: begin
        cmd_o.mask_wr = 1'b1;
        state_d = S_DONE;
      end
      S_TICK: begin
        cmd_o.tick_inc = 1'b1;
        cmd_o.pc_init  = 1'b1;
        state_d = S_PC;
      end
      S_PC: begin
        cmd_o.pc_step = 1'b1;
        if (sts_i.bit_last) state_d = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_SELI;
      end
      S_SELI: begin
        cmd_o.sel_init = 1'b1;
        state_d = sts_i.pc_zero ? S_SCAN_RD : S_SEL;
      end
      S_SEL: begin
        cmd_o.sel_step = 1'b1;
        if (sts_i.sel_hit) state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.match || sts_i.way_last) state_d = S_WR;
        else state_d = S_SCAN_RD;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d = S_DONE;
      end
      S_RLD_RD: begin
        cmd_o.rd  = 1'b1;
        cmd_o.rld = 1'b1;
        state_d = S_RLD_CK;
      end
      S_RLD_CK: begin
        cmd_o.chk = 1'b1;
        cmd_o.rld = 1'b1;
        // a miss anywhere falls through to a normal access
        if (sts_i.match) state_d = S_DONE;
        else if (sts_i.way_last && sts_i.set_last) state_d = S_TICK;
        else state_d = S_RLD_RD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

// ===== sv/task_masked_lru_cache_top.sv =====
// steps from acceptance: a mask write or an unknown type goes straight to the result; an access
// runs a mask popcount, a line remainder, a set select and a read and check per way until a match
// a reload reads and checks every way of every set in use before a miss falls into the access steps
// one item at a time: ready returns the cycle after the result is loaded; the last step
// stalls only while the previous result still sits unread in the output register
// after reset a clearing pass zeroes the entry ram, ready stays low
module task_masked_lru_cache_top #(
  parameter int unsigned MaxSets   = tmlc_pkg::MaxSetsDef,
  parameter int unsigned MaxWays   = tmlc_pkg::MaxWaysDef,
  parameter int unsigned TaskSlots = tmlc_pkg::TaskSlotsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tmlc_pkg::CFGIDX_W-1:0]  cfg_idx_i,
  input  logic [tmlc_pkg::SETC_W-1:0]    cfg_data_i,
  tmlc_req_if.sink                       req_i,
  tmlc_rsp_if.source                     rsp_o
);

  tmlc_pkg::cmd_t cmd;
  tmlc_pkg::sts_t sts;

  tmlc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_req_type_i (req_i.req_type),
    .in_ready_o    (req_i.ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  tmlc_dp #(
    .MaxSets   (MaxSets),
    .MaxWays   (MaxWays),
    .TaskSlots (TaskSlots)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_data_i              (cfg_data_i),
    .task_id_i               (req_i.task_id),
    .line_number_i           (req_i.line_number),
    .mask_value_i            (req_i.mask_value),
    .out_ready_i             (rsp_o.ready),
    .out_valid_o             (rsp_o.valid),
    .hit_o                   (rsp_o.hit),
    .evicted_valid_o         (rsp_o.evicted_valid),
    .victim_task_o           (rsp_o.victim_task),
    .evicted_line_o          (rsp_o.evicted_line),
    .cross_evictions_total_o (rsp_o.cross_evictions_total)
  );

endmodule

// ===== tb/tmlc_checker.sv =====
// checker: tracks cache contents, predicts each response and compares it with the block
module tmlc_checker import tmlc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFGIDX_W-1:0] cfg_idx_i,
  input  logic [SETC_W-1:0]   cfg_data_i,
  tmlc_req_if                 req_mon,
  tmlc_rsp_if                 rsp_mon,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o,
  output int unsigned         hits_o,
  output int unsigned         cross_o
);

  localparam int unsigned NumEntries = MaxSetsDef * MaxWaysDef;

  typedef struct packed {
    logic               hit;
    logic               ev_valid;
    logic [TASK_W-1:0]  ev_owner;
    logic [LINE_W-1:0]  ev_line;
    logic [TOTAL_W-1:0] total;
  } cache_rsp_t;

  cache_rsp_t rsp_q[$];

  logic [SETC_W-1:0]  set_cfg;
  logic [WAYC_W-1:0]  way_cfg;
  logic               ent_valid [NumEntries];
  logic [TASK_W-1:0]  ent_owner [NumEntries];
  logic [LINE_W-1:0]  ent_line  [NumEntries];
  logic [TOUCH_W-1:0] ent_touch [NumEntries];
  logic [TOUCH_W-1:0] tick;
  logic [TOTAL_W-1:0] cross_total;
  logic [MASK_W-1:0]  task_masks [TaskSlotsDef];

  int unsigned fails, checked, hits, crosses;

  function automatic int unsigned sets_used();
    if (set_cfg == 0) return 1;
    if (set_cfg > MaxSetsDef) return MaxSetsDef;
    return set_cfg;
  endfunction

  function automatic int unsigned ways_used();
    if (way_cfg == 0) return 1;
    if (way_cfg > MaxWaysDef) return MaxWaysDef;
    return way_cfg;
  endfunction

  // the (line mod popcount)-th enabled set, or line mod sets when none enabled
  function automatic int unsigned home_set(logic [TASK_W-1:0] tid, logic [LINE_W-1:0] ln);
    int unsigned n;
    int unsigned pc;
    int unsigned ord;
    logic [MASK_W-1:0] m;
    n = sets_used();
    m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    m = m & task_masks[tid % TaskSlotsDef];
    pc = $countones(m);
    if (pc == 0) return ln % n;
    ord = ln % pc;
    for (int s = 0; s < 64; s++) begin
      if (m[s]) begin
        if (ord == 0) return s;
        ord--;
      end
    end
    return 0;
  endfunction

  function automatic cache_rsp_t place_line(logic [TASK_W-1:0] tid, logic [LINE_W-1:0] ln);
    cache_rsp_t r;
    int unsigned base;
    int unsigned victim;
    int unsigned e;
    logic found;
    logic [TOUCH_W-1:0] oldest;
    r = '0;
    base = home_set(tid, ln) * MaxWaysDef;
    victim = 0;
    found = 1'b0;
    for (int w = 0; w < ways_used(); w++) begin
      if (!found && !ent_valid[base + w]) begin
        victim = w;
        found = 1'b1;
      end
    end
    if (!found) begin
      oldest = ent_touch[base];
      for (int w = 1; w < ways_used(); w++) begin
        if (ent_touch[base + w] < oldest) begin
          oldest = ent_touch[base + w];
          victim = w;
        end
      end
    end
    e = base + victim;
    if (ent_valid[e] && ent_owner[e] != tid) begin
      cross_total++;
      r.ev_valid = 1'b1;
      r.ev_owner = ent_owner[e];
      r.ev_line  = ent_line[e];
    end
    ent_valid[e] = 1'b1;
    ent_owner[e] = tid;
    ent_line[e]  = ln;
    ent_touch[e] = tick;
    return r;
  endfunction

  function automatic cache_rsp_t predict_lookup(logic [REQ_W-1:0] rt, logic [TASK_W-1:0] tid,
                                                logic [LINE_W-1:0] ln, logic [MASK_W-1:0] mv);
    cache_rsp_t r;
    int unsigned base;
    int unsigned e;
    logic found;
    r = '0;
    found = 1'b0;
    if (rt == REQ_ACCESS) begin
      tick++;
      base = home_set(tid, ln) * MaxWaysDef;
      for (int w = 0; w < ways_used(); w++) begin
        e = base + w;
        if (!found && ent_valid[e] && ent_owner[e] == tid && ent_line[e] == ln) begin
          ent_touch[e] = tick;
          found = 1'b1;
        end
      end
      if (found) r.hit = 1'b1;
      else r = place_line(tid, ln);
    end else if (rt == REQ_RELOAD) begin
      // whole-cache search, no tick unless it misses
      for (int s = 0; s < sets_used(); s++) begin
        for (int w = 0; w < ways_used(); w++) begin
          e = s * MaxWaysDef + w;
          if (ent_valid[e] && ent_owner[e] == tid && ent_line[e] == ln) found = 1'b1;
        end
      end
      if (found) begin
        r.hit = 1'b1;
      end else begin
        tick++;
        r = place_line(tid, ln);
      end
    end else if (rt == REQ_MASK) begin
      task_masks[tid % TaskSlotsDef] = mv;
    end
    r.total = cross_total;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_rsp_t want;
    cache_rsp_t got;
    if (!rst_ni) begin
      set_cfg = SET_COUNT_RST;
      way_cfg = WAY_COUNT_RST;
      for (int i = 0; i < NumEntries; i++) begin
        ent_valid[i] = 1'b0;
        ent_owner[i] = '0;
        ent_line[i]  = '0;
        ent_touch[i] = '0;
      end
      for (int i = 0; i < TaskSlotsDef; i++) task_masks[i] = '1;
      tick = '0;
      cross_total = '0;
      rsp_q.delete();
      fails = 0;
      checked = 0;
      hits = 0;
      crosses = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.hit, rsp_mon.evicted_valid, rsp_mon.victim_task,
                rsp_mon.evicted_line, rsp_mon.cross_evictions_total};
        if (rsp_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected response item: %p", got);
        end else begin
          want = rsp_q.pop_front();
          checked++;
          if (got.hit) hits++;
          if (got.ev_valid) crosses++;
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch at response %0d", checked);
              $display("  expected hit=%0b ev=%0b owner=%0d line=%h total=%0d",
                       want.hit, want.ev_valid, want.ev_owner, want.ev_line, want.total);
              $display("  actual   hit=%0b ev=%0b owner=%0d line=%h total=%0d",
                       got.hit, got.ev_valid, got.ev_owner, got.ev_line, got.total);
            end
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        rsp_q.push_back(predict_lookup(req_mon.req_type, req_mon.task_id,
                                       req_mon.line_number, req_mon.mask_value));
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SET_COUNT) set_cfg = cfg_data_i;
        else way_cfg = cfg_data_i[WAYC_W-1:0];
      end
    end
    fail_count_o <= fails;
    pending_o <= rsp_q.size();
    checked_o <= checked;
    hits_o <= hits;
    cross_o <= crosses;
  end

endmodule

// ===== tb/tb.sv =====
// testbench top: clock, reset, request and register stimulus, verdict
module tb;
  import tmlc_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned NumPhases = 7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFGIDX_W-1:0] cfg_idx_i;
  logic [SETC_W-1:0]   cfg_data_i;

  int unsigned fail_count, pending, checked, hit_count, cross_count;
  int unsigned gap_pct, stall_pct, sent;

  tmlc_req_if req_if ();
  tmlc_rsp_if rsp_if ();

  task_masked_lru_cache_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  tmlc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .hits_o       (hit_count),
    .cross_o      (cross_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // response side backpressure
  initial rsp_if.ready = 1'b0;
  always @(posedge clk_i) rsp_if.ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_item(logic [REQ_W-1:0] rt, logic [TASK_W-1:0] tid,
                           logic [LINE_W-1:0] ln, logic [MASK_W-1:0] mv);
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= rt;
    req_if.task_id     <= tid;
    req_if.line_number <= ln;
    req_if.mask_value  <= mv;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // the caller drops the write enable after its last write
  task automatic write_reg(logic [CFGIDX_W-1:0] idx, logic [SETC_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  function automatic logic [MASK_W-1:0] rand_mask();
    logic [MASK_W-1:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(4))
      0: m = '1;
      1: m = '0;
      2: m = 64'd1 << $urandom_range(63);
      3: m = m & {$urandom, $urandom} & {$urandom, $urandom};
      default: ;
    endcase
    return m;
  endfunction

  task automatic random_item();
    int unsigned pick;
    logic [REQ_W-1:0] rt;
    logic [TASK_W-1:0] tid;
    logic [LINE_W-1:0] ln;
    pick = $urandom_range(99);
    if (pick < 10) rt = REQ_MASK;
    else if (pick < 13) rt = REQ_UNUSED;
    else if (pick < 38) rt = REQ_RELOAD;
    else rt = REQ_ACCESS;
    // a few busy tasks and a small line pool so hits and evictions both happen
    tid = ($urandom_range(99) < 70) ? TASK_W'($urandom_range(3)) : TASK_W'($urandom_range(15));
    ln = ($urandom_range(99) < 80) ? LINE_W'($urandom_range(47)) : LINE_W'($urandom);
    send_item(rt, tid, ln, (rt == REQ_MASK) ? rand_mask() : {$urandom, $urandom});
  endtask

  initial begin
    logic [SETC_W-1:0] set_vals [NumPhases];
    logic [SETC_W-1:0] way_vals [NumPhases];
    set_vals = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd17, 7'd64};
    way_vals = '{7'd8, 7'd1, 7'd0, 7'd15, 7'd3, 7'd8, 7'd2};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SET_COUNT;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_ACCESS;
    req_if.task_id = '0;
    req_if.line_number = '0;
    req_if.mask_value = '0;
    gap_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: mask extremes, hit and miss, reload, unknown type, eviction chains
    send_item(REQ_MASK, 4'd0, '0, '1);
    send_item(REQ_MASK, 4'd1, '0, 64'h8000_0000_0000_0000);
    send_item(REQ_MASK, 4'd2, '0, '0);
    send_item(REQ_ACCESS, 4'd0, '0, '0);
    send_item(REQ_ACCESS, 4'd0, '0, '1);
    send_item(REQ_RELOAD, 4'd0, '0, '0);
    send_item(REQ_RELOAD, 4'd15, '1, '0);
    send_item(REQ_UNUSED, 4'd15, '1, '1);
    // task 1 only owns set 63: nine lines fill it and evict its own oldest
    for (int i = 0; i < 9; i++) send_item(REQ_ACCESS, 4'd1, LINE_W'(i), '0);
    // empty mask falls back to line mod sets, landing in set 63 too
    send_item(REQ_ACCESS, 4'd2, 31'd63, '0);
    send_item(REQ_RELOAD, 4'd1, 31'd8, '0);
    send_item(REQ_ACCESS, 4'd14, '1, '0);

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        drain();
        write_reg(CFG_SET_COUNT, set_vals[p]);
        write_reg(CFG_WAY_COUNT, way_vals[p]);
        cfg_we_i <= 1'b0;
      end
      case (p % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 56; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 56; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      for (int i = 0; i < 90; i++) random_item();
    end
    drain();
    repeat (200) @(posedge clk_i);

    $display("sent %0d requests across %0d register settings, %0d responses checked",
             sent, NumPhases, checked);
    $display("saw %0d hits and %0d cross-task evictions", hit_count, cross_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
